### rtl/core/ggs_pkg.sv
package ggs_pkg;

	// cordic configuration
	localparam int CORDIC_STEPS = 16;
	localparam int COORD_WIDTH  = 16;

	// field widths
	localparam int POS_W  = 16;
	localparam int HEAD_W = 15;
	localparam int GAIN_W = 12;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 16;

	// datapath widths
	localparam int DELTA_W = POS_W + 1;
	localparam int XY_W    = DELTA_W + COORD_WIDTH + 3;
	localparam int Z_W     = 34;
	localparam int BEAR_W  = 16;
	localparam int DIFF_W  = BEAR_W + 1;
	localparam int MAG_W   = 34;
	localparam int HALF_W  = MAG_W / 2;
	localparam int INV_W   = 30;
	localparam int PROD_W  = 64;
	localparam int DIST_W  = 18;
	localparam int RPROD_W = GAIN_W + 1 + DIFF_W;
	localparam int SPROD_W = GAIN_W + DIST_W;

	// magnitude renormalization to 16 fraction bits
	localparam int MAG_SHR = (COORD_WIDTH >= 16) ? COORD_WIDTH - 16 : 0;
	localparam int MAG_SHL = (COORD_WIDTH >= 16) ? 0 : 16 - COORD_WIDTH;

	localparam logic [INV_W-1:0]      INV_GAIN = 30'h26DD3B6A;
	localparam logic signed [Z_W-1:0] HALF_PI  = 34'sh06487ED51;

	// queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_GOAL_X     = 3'd0,
		REG_GOAL_Y     = 3'd1,
		REG_TURN_GAIN  = 3'd2,
		REG_SPEED_GAIN = 3'd3,
		REG_ARRIVE     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
		logic [GAIN_W-1:0]       turn_gain;
		logic [GAIN_W-1:0]       speed_gain;
		logic [DATA_W-1:0]       arrive_distance;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [Z_W-1:0]    z;
		logic                     zero;
		logic signed [HEAD_W-1:0] heading;
	} vec_t;

	// truncated atan(2^-i) in Q4.30
	function automatic logic signed [Z_W-1:0] atan_q30(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:  r = 34'sh03243F6A8;
			1:  r = 34'sh01DAC6705;
			2:  r = 34'sh00FADBAFC;
			3:  r = 34'sh007F56EA6;
			4:  r = 34'sh003FEAB76;
			5:  r = 34'sh001FFD55B;
			6:  r = 34'sh000FFFAAA;
			7:  r = 34'sh0007FFF55;
			8:  r = 34'sh0003FFFEA;
			9:  r = 34'sh0001FFFFD;
			10: r = 34'sh0000FFFFF;
			11: r = 34'sh00007FFFF;
			12: r = 34'sh00003FFFF;
			13: r = 34'sh00001FFFF;
			14: r = 34'sh00000FFFF;
			15: r = 34'sh000007FFF;
			16: r = 34'sh000003FFF;
			17: r = 34'sh000001FFF;
			18: r = 34'sh000000FFF;
			19: r = 34'sh0000007FF;
			20: r = 34'sh0000003FF;
			21: r = 34'sh0000001FF;
			22: r = 34'sh0000000FF;
			23: r = 34'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/ggs_if.sv
interface ggs_pose_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ggs_pkg::POS_W-1:0]      pose_x;
	logic signed [ggs_pkg::POS_W-1:0]      pose_y;
	logic signed [ggs_pkg::HEAD_W-1:0]     heading;
	modport source (output valid, pose_x, pose_y, heading, input ready);
	modport sink (input valid, pose_x, pose_y, heading, output ready);
endinterface

interface ggs_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ggs_pkg::POS_W-1:0]      turn_rate;
	logic [ggs_pkg::POS_W-1:0]             forward_speed;
	logic                                  arrived;
	modport source (output valid, turn_rate, forward_speed, arrived, input ready);
	modport sink (input valid, turn_rate, forward_speed, arrived, output ready);
endinterface

interface ggs_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [ggs_pkg::IDX_W-1:0]             index;
	logic [ggs_pkg::DATA_W-1:0]            data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/go_to_goal_steering.sv
// a pose passes the queue, entry, cordic, multiply and output registers in turn
// throughput: one pose per cycle; a 16-stage cordic pipeline and two multiply
// stages all advance together while the output word is free or being taken
// a two-word queue sits between the pose classifier and the cordic pipeline
// reset: arst_n clears queue and pipeline valids and loads register defaults
module go_to_goal_steering (
	input  logic       clk,
	input  logic       arst_n,
	ggs_pose_if.sink   pose,
	ggs_cmd_if.source  cmd,
	ggs_cfg_if.sink    cfg
);
	ggs_pkg::cfg_t cfg_q;
	ggs_pkg::vec_t front_word;
	ggs_pkg::vec_t head_word;
	logic          q_full;
	logic          q_nonempty;
	logic          q_pop;
	logic          push;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_x <= '0;
			cfg_q.goal_y <= '0;
			cfg_q.turn_gain <= 12'd1024;
			cfg_q.speed_gain <= 12'd128;
			cfg_q.arrive_distance <= 16'd26;
		end else if (cfg.valid) begin
			case (ggs_pkg::reg_idx_t'(cfg.index))
				ggs_pkg::REG_GOAL_X: cfg_q.goal_x <= cfg.data;
				ggs_pkg::REG_GOAL_Y: cfg_q.goal_y <= cfg.data;
				ggs_pkg::REG_TURN_GAIN: cfg_q.turn_gain <= cfg.data[ggs_pkg::GAIN_W-1:0];
				ggs_pkg::REG_SPEED_GAIN: cfg_q.speed_gain <= cfg.data[ggs_pkg::GAIN_W-1:0];
				ggs_pkg::REG_ARRIVE: cfg_q.arrive_distance <= cfg.data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// pose intake
	assign pose.ready = !q_full;
	assign push = pose.valid && !q_full;

	ggs_front u_front (
		.cfg     (cfg_q),
		.pose_x  (pose.pose_x),
		.pose_y  (pose.pose_y),
		.heading (pose.heading),
		.vec     (front_word)
	);

	ggs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (front_word),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (head_word)
	);

	ggs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (q_nonempty),
		.in_word  (head_word),
		.pop      (q_pop),
		.cmd      (cmd)
	);
endmodule

### rtl/core/ggs_front.sv
module ggs_front (
	input  ggs_pkg::cfg_t cfg,
	input  logic [ggs_pkg::POS_W-1:0] pose_x,
	input  logic [ggs_pkg::POS_W-1:0] pose_y,
	input  logic [ggs_pkg::HEAD_W-1:0] heading,
	output ggs_pkg::vec_t vec
);
	logic signed [ggs_pkg::DELTA_W-1:0] dx;
	logic signed [ggs_pkg::DELTA_W-1:0] dy;
	logic signed [ggs_pkg::DELTA_W-1:0] rx;
	logic signed [ggs_pkg::DELTA_W-1:0] ry;

	// goal minus pose, then pre-rotate the left half plane by +-pi/2
	always_comb begin
		dx = {cfg.goal_x[ggs_pkg::POS_W-1], cfg.goal_x} - {pose_x[ggs_pkg::POS_W-1], pose_x};
		dy = {cfg.goal_y[ggs_pkg::POS_W-1], cfg.goal_y} - {pose_y[ggs_pkg::POS_W-1], pose_y};
		rx = dx;
		ry = dy;
		vec.z = '0;
		if (dx < 0) begin
			if (dy >= 0) begin
				rx = dy;
				ry = -dx;
				vec.z = ggs_pkg::HALF_PI;
			end else begin
				rx = -dy;
				ry = dx;
				vec.z = -ggs_pkg::HALF_PI;
			end
		end
		vec.x = ggs_pkg::XY_W'(rx) <<< ggs_pkg::COORD_WIDTH;
		vec.y = ggs_pkg::XY_W'(ry) <<< ggs_pkg::COORD_WIDTH;
		vec.zero = (dx == '0) && (dy == '0);
		vec.heading = heading;
	end
endmodule

### rtl/core/ggs_queue.sv
module ggs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ggs_pkg::vec_t push_word,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output ggs_pkg::vec_t head
);
	ggs_pkg::vec_t mem_q [ggs_pkg::QUEUE_DEPTH];
	logic [ggs_pkg::QPTR_W-1:0] wptr_q;
	logic [ggs_pkg::QPTR_W-1:0] rptr_q;
	logic [ggs_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == ggs_pkg::QCNT_W'(ggs_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == ggs_pkg::QPTR_W'(ggs_pkg::QUEUE_DEPTH - 1)) ? '0
					: wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == ggs_pkg::QPTR_W'(ggs_pkg::QUEUE_DEPTH - 1)) ? '0
					: rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

### rtl/core/ggs_back.sv
module ggs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ggs_pkg::cfg_t cfg,
	input  logic          in_valid,
	input  ggs_pkg::vec_t in_word,
	output logic          pop,
	ggs_cmd_if.source     cmd
);
	localparam int N = ggs_pkg::CORDIC_STEPS;

	logic en;

	logic signed [ggs_pkg::XY_W-1:0]   x_s [N+1];
	logic signed [ggs_pkg::XY_W-1:0]   y_s [N+1];
	logic signed [ggs_pkg::Z_W-1:0]    z_s [N+1];
	logic                              zero_s [N+1];
	logic signed [ggs_pkg::HEAD_W-1:0] hd_s [N+1];
	logic                              v_s [N+1];

	logic                                    v_sa;
	logic signed [ggs_pkg::DIFF_W-1:0]       diff_sa;
	logic [ggs_pkg::HALF_W+ggs_pkg::INV_W-1:0] plo_sa;
	logic [ggs_pkg::HALF_W+ggs_pkg::INV_W-1:0] phi_sa;

	logic                                v_sb;
	logic signed [ggs_pkg::RPROD_W-1:0]  rprod_sb;
	logic [ggs_pkg::DIST_W-1:0]          dist_sb;

	logic                                out_valid_q;
	logic signed [ggs_pkg::POS_W-1:0]    rate_q;
	logic [ggs_pkg::POS_W-1:0]           speed_q;
	logic                                arrived_q;

	// whole pipeline moves unless the output word is held
	assign en = !out_valid_q || cmd.ready;
	assign pop = en && in_valid;

	// entry stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= in_word.x;
			y_s[0] <= in_word.y;
			z_s[0] <= in_word.z;
			zero_s[0] <= in_word.zero;
			hd_s[0] <= in_word.heading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// one cordic vectoring iteration per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ggs_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ggs_pkg::atan_q30(i);
				end
				zero_s[i+1] <= zero_s[i];
				hd_s[i+1] <= hd_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	// bearing rounding, angle error and split magnitude scaling
	logic signed [ggs_pkg::Z_W-1:0]    zr;
	logic signed [ggs_pkg::BEAR_W-1:0] bear;
	logic [ggs_pkg::XY_W-1:0]          xp;
	logic [ggs_pkg::XY_W+15:0]         uxw;
	logic [ggs_pkg::MAG_W-1:0]         ux;

	always_comb begin
		zr = (z_s[N] + ggs_pkg::Z_W'(1 << 17)) >>> 18;
		bear = zero_s[N] ? '0 : zr[ggs_pkg::BEAR_W-1:0];
		xp = (x_s[N] > 0) ? x_s[N] : '0;
		uxw = ({16'b0, xp} >> ggs_pkg::MAG_SHR) << ggs_pkg::MAG_SHL;
		ux = uxw[ggs_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_sa <= ggs_pkg::DIFF_W'(bear) - ggs_pkg::DIFF_W'(hd_s[N]);
			plo_sa <= ux[ggs_pkg::HALF_W-1:0] * ggs_pkg::INV_GAIN;
			phi_sa <= ux[ggs_pkg::MAG_W-1:ggs_pkg::HALF_W] * ggs_pkg::INV_GAIN;
		end
	end

	// distance and turn product
	logic [ggs_pkg::PROD_W-1:0] prod;
	logic [ggs_pkg::PROD_W-1:0] prod_r;

	always_comb begin
		prod = (ggs_pkg::PROD_W'(phi_sa) << ggs_pkg::HALF_W) + ggs_pkg::PROD_W'(plo_sa);
		prod_r = (prod + (ggs_pkg::PROD_W'(1) << 45)) >> 46;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_sb <= prod_r[ggs_pkg::DIST_W-1:0];
			rprod_sb <= ggs_pkg::RPROD_W'($signed({1'b0, cfg.turn_gain}))
				* ggs_pkg::RPROD_W'(diff_sa);
		end
	end

	// speed product, rounding and saturation into the output word
	logic [ggs_pkg::SPROD_W-1:0]          sprod;
	logic [ggs_pkg::SPROD_W-1:0]          sround;
	logic [ggs_pkg::SPROD_W-9:0]          speed;
	logic signed [ggs_pkg::RPROD_W-1:0]   rate;
	logic signed [ggs_pkg::POS_W-1:0]     rate_sat;
	logic [ggs_pkg::POS_W-1:0]            speed_sat;

	always_comb begin
		sprod = ggs_pkg::SPROD_W'(cfg.speed_gain) * ggs_pkg::SPROD_W'(dist_sb);
		sround = sprod + ggs_pkg::SPROD_W'(128);
		speed = sround[ggs_pkg::SPROD_W-1:8];
		speed_sat = (speed > (ggs_pkg::SPROD_W-8)'(16'hFFFF)) ? 16'hFFFF
			: speed[ggs_pkg::POS_W-1:0];
		rate = (rprod_sb + ggs_pkg::RPROD_W'(2048)) >>> 12;
		if (rate > ggs_pkg::RPROD_W'(32767)) begin
			rate_sat = 16'sh7FFF;
		end else if (rate < -ggs_pkg::RPROD_W'(32768)) begin
			rate_sat = -16'sh8000;
		end else begin
			rate_sat = rate[ggs_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rate_q <= rate_sat;
			speed_q <= speed_sat;
			arrived_q <= (dist_sb < ggs_pkg::DIST_W'(cfg.arrive_distance));
		end
	end

	// valid bits of the tail stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_sa <= v_s[N];
			v_sb <= v_sa;
			out_valid_q <= v_sb;
		end
	end

	assign cmd.valid = out_valid_q;
	assign cmd.turn_rate = rate_q;
	assign cmd.forward_speed = speed_q;
	assign cmd.arrived = arrived_q;
endmodule
